[rtl/ctb_pkg.sv]
`default_nettype none

package ctb_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 11;
   localparam int SUM_W    = CNT_W + 1;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_LEFT   = 2'd1;
   localparam logic [1:0] MODE_RIGHT  = 2'd2;
   localparam logic [1:0] MODE_READ   = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
      logic [9:0] position;
   } req_type;

   typedef struct packed {
      logic [7:0]       read_char;
      logic             read_valid;
      logic             rejected;
      logic [CNT_W-1:0] left_length;
      logic [CNT_W-1:0] right_length;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/ctb_ram.sv]
`default_nettype none

module ctb_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/cursor_text_buffer.sv]
// Channel   Handshake              Payload            Transfer
// command   start / busy           req_data req_type  edge with start && !busy
// result    rsp_valid (strobe)     rsp_data rsp_type  edge ending the strobe cycle
//
// Inserts, moves on an empty side and reads outside the text end in EXEC; moves that shift
// a character and reads inside the text also pass through FINISH, as the two stack memories
// have registered read ports (read in EXEC, write back or answer in FINISH).
// Each result is registered and shows in the cycle after its command's last state; the next command may transfer
// in that same cycle. Synchronous reset empties both stacks through the counts only;
// memory contents are not cleared. The receiver cannot stall.
`default_nettype none

module cursor_text_buffer import ctb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] bc_ff, bc_in;
   logic [CNT_W-1:0] ac_ff, ac_in;
   logic             sel_after_ff, sel_after_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic              b_we, a_we;
   logic [ADDR_W-1:0] b_waddr, a_waddr, b_raddr, a_raddr;
   logic [7:0]        b_wdata, a_wdata, b_rdata, a_rdata;

   logic [SUM_W-1:0] total;
   logic [CNT_W-1:0] diff, after_idx;
   logic [CNT_W-1:0] pos_ext;

   ctb_ram #(.DEPTH(CAPACITY), .WIDTH(8)) u_before (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   ctb_ram #(.DEPTH(CAPACITY), .WIDTH(8)) u_after (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign total     = {1'b0, bc_ff} + {1'b0, ac_ff};
   assign pos_ext   = {{(CNT_W-10){1'b0}}, req_ff.position};
   assign diff      = pos_ext - bc_ff;
   assign after_idx = ac_ff - CNT_W'(1) - diff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      bc_in        = bc_ff;
      ac_in        = ac_ff;
      sel_after_in = sel_after_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      b_we    = 1'b0;
      a_we    = 1'b0;
      b_waddr = bc_ff[ADDR_W-1:0];
      a_waddr = ac_ff[ADDR_W-1:0];
      b_wdata = req_ff.char_code;
      a_wdata = b_rdata;
      b_raddr = bc_ff[ADDR_W-1:0] - ADDR_W'(1);
      a_raddr = ac_ff[ADDR_W-1:0] - ADDR_W'(1);

      // default answer: nothing read, nothing rejected, current counts
      rsp_in.read_char    = 8'd0;
      rsp_in.read_valid   = 1'b0;
      rsp_in.rejected     = 1'b0;
      rsp_in.left_length  = bc_ff;
      rsp_in.right_length = ac_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (req_ff.mode)
               MODE_INSERT: begin
                  rsp_valid_in = 1'b1;
                  if (total >= SUM_W'(CAPACITY)) begin
                     rsp_in.rejected = 1'b1;
                  end else begin
                     b_we              = 1'b1;
                     bc_in             = bc_ff + CNT_W'(1);
                     rsp_in.left_length = bc_in;
                  end
               end
               MODE_LEFT: begin
                  if (bc_ff != '0 && ac_ff < CNT_W'(CAPACITY)) begin
                     state_in = ST_FINISH;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               MODE_RIGHT: begin
                  if (ac_ff != '0 && bc_ff < CNT_W'(CAPACITY)) begin
                     state_in = ST_FINISH;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               MODE_READ: begin
                  b_raddr = req_ff.position[ADDR_W-1:0];
                  a_raddr = after_idx[ADDR_W-1:0];
                  if (pos_ext < bc_ff) begin
                     sel_after_in = 1'b0;
                     state_in     = ST_FINISH;
                  end else if (diff < ac_ff) begin
                     sel_after_in = 1'b1;
                     state_in     = ST_FINISH;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_FINISH: begin
            // read data from the EXEC cycle is on rd_data now; the write lands before
            // the next command can issue a read, so no forwarding path is needed
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (req_ff.mode)
               MODE_LEFT: begin
                  a_we    = 1'b1;
                  a_wdata = b_rdata;
                  bc_in   = bc_ff - CNT_W'(1);
                  ac_in   = ac_ff + CNT_W'(1);
               end
               MODE_RIGHT: begin
                  b_we    = 1'b1;
                  b_wdata = a_rdata;
                  bc_in   = bc_ff + CNT_W'(1);
                  ac_in   = ac_ff - CNT_W'(1);
               end
               MODE_READ: begin
                  rsp_in.read_char  = sel_after_ff ? a_rdata : b_rdata;
                  rsp_in.read_valid = 1'b1;
               end
               default: ;
            endcase
            rsp_in.left_length  = bc_in;
            rsp_in.right_length = ac_in;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bc_ff        <= '0;
         ac_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bc_ff        <= bc_in;
         ac_ff        <= ac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      sel_after_ff <= sel_after_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

[rtl/ctb_checker.sv]
`default_nettype none

module ctb_checker import ctb_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // an accepted command holds the port until it finishes
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after command transfer");

   // every command passes through IDLE and EXEC before its strobe, so strobes never touch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.read_valid) |-> (rsp_data.read_char == 8'd0))
      else $error("read_char nonzero without read_valid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.rejected && rsp_data.read_valid))
      else $error("rejected and read_valid together");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, rsp_data.left_length} + {1'b0, rsp_data.right_length})
                     <= SUM_W'(CAPACITY)))
      else $error("text length beyond capacity");

endmodule

bind cursor_text_buffer ctb_checker u_ctb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
